FILE: hdl/rtsp_ipe_pkg.sv
// Shared constants for the RTSP interleaved payload extractor.
package rtsp_ipe_pkg;

  localparam int FRAME_HEADER_BYTES = 4;

  localparam logic [7:0] MARKER = 8'h24;

  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PH_HUNT    = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SKIP    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RTP_LEN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ASF_LEN = 2'd2;

  localparam int HDR_LEN_W = 6;
  localparam int POS_W     = 7;
  localparam int LEN_W     = 16;

  localparam logic [HDR_LEN_W-1:0] RTP_LEN_RESET = 6'd12;
  localparam logic [HDR_LEN_W-1:0] ASF_LEN_RESET = 6'd4;

endpackage

FILE: hdl/rtsp_interleaved_payload_extractor.sv
// RTSP interleaved frame deframer: hunts the marker, skips headers, streams payload bytes.
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid/s_axis_tready    tdata[7:0] = data_byte
// m_axis    out        m_axis_tvalid/m_axis_tready    tdata[7:0] = payload_byte, tlast
// cfg       in         cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One byte per cycle while not stalled; each byte is decided in the cycle it is taken and
// any result lands in the output register on that edge, visible in the cycle after its byte.
// Reset clears the frame state and loads the register defaults; the block starts disabled.
// Input stalls only while the output register holds a result that is not being taken.
// Configuration writes are always taken; cfg_ready is held high.
module rtsp_interleaved_payload_extractor
  import rtsp_ipe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] payload_byte
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [HDR_LEN_W-1:0]   cfg_data
);

  logic                 deframe_enable;
  logic [HDR_LEN_W-1:0] rtp_header_len;
  logic [HDR_LEN_W-1:0] asf_header_len;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [POS_W-1:0]   header_position, header_position_next;
  logic [7:0]         length_high, length_high_next;
  logic [LEN_W-1:0]   payload_remaining, payload_remaining_next;

  logic       in_take;
  logic       out_load;
  logic       last_flag;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_dec;
  logic [POS_W-1:0] skip;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] skip_ext;
  logic [LEN_W-1:0] new_remaining;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deframe_enable <= 1'b0;
      rtp_header_len <= RTP_LEN_RESET;
      asf_header_len <= ASF_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:  deframe_enable <= cfg_data[0];
        REG_RTP_LEN: rtp_header_len <= cfg_data;
        REG_ASF_LEN: asf_header_len <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_inc       = header_position + POS_W'(1);
  assign pos_dec       = header_position - POS_W'(1);
  assign skip          = POS_W'(rtp_header_len) + POS_W'(asf_header_len);
  assign frame_len     = {length_high, s_axis_tdata};
  assign skip_ext      = LEN_W'(skip);
  assign new_remaining = (frame_len > skip_ext) ? (frame_len - skip_ext) : '0;
  assign last_flag     = (payload_remaining <= LEN_W'(1));

  always_comb begin
    phase_next             = phase;
    header_position_next   = header_position;
    length_high_next       = length_high;
    payload_remaining_next = payload_remaining;
    out_load               = 1'b0;
    if (in_take) begin
      if (!deframe_enable) begin
        phase_next             = PH_HUNT;
        header_position_next   = '0;
        length_high_next       = '0;
        payload_remaining_next = '0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (s_axis_tdata == MARKER) begin
              phase_next           = PH_HEADER;
              header_position_next = POS_W'(1);
            end
          end
          PH_HEADER: begin
            if (header_position == POS_W'(2)) begin
              length_high_next = s_axis_tdata;
            end
            header_position_next = pos_inc;
            if (pos_inc >= POS_W'(FRAME_HEADER_BYTES)) begin
              payload_remaining_next = new_remaining;
              if (skip == '0) begin
                phase_next           = (new_remaining != '0) ? PH_PAYLOAD : PH_HUNT;
                header_position_next = '0;
              end else begin
                phase_next           = PH_SKIP;
                header_position_next = skip;
              end
            end
          end
          PH_SKIP: begin
            header_position_next = pos_dec;
            if (pos_dec == '0) begin
              phase_next = (payload_remaining != '0) ? PH_PAYLOAD : PH_HUNT;
            end
          end
          PH_PAYLOAD: begin
            out_load = 1'b1;
            if (last_flag) begin
              payload_remaining_next = '0;
              phase_next             = PH_HUNT;
              header_position_next   = '0;
            end else begin
              payload_remaining_next = payload_remaining - LEN_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      header_position   <= '0;
      length_high       <= '0;
      payload_remaining <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_position   <= header_position_next;
      length_high       <= length_high_next;
      payload_remaining <= payload_remaining_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= s_axis_tdata;
      m_axis_tlast <= last_flag;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_remaining != '0)
    else $error("payload phase with nothing left to emit");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> header_position != '0)
    else $error("skip phase with zero count");

  a_header_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |->
      (header_position >= POS_W'(1)) &&
      (header_position < POS_W'(FRAME_HEADER_BYTES)))
    else $error("frame header position out of range");

  a_last_to_hunt: assert property (@(posedge clk) disable iff (rst)
    out_load && last_flag |=> phase == PH_HUNT && m_axis_tvalid && m_axis_tlast)
    else $error("last payload byte did not end the packet");

  a_disable_clears: assert property (@(posedge clk) disable iff (rst)
    in_take && !deframe_enable |=> phase == PH_HUNT && payload_remaining == '0)
    else $error("disabled byte did not clear frame state");

endmodule
